### src/ots_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ots_pkg
// Shared types, token kinds and character codes of the operator token scanner.
// ---------------------------------------------------------------------------
package ots_pkg;

    localparam int POS_BITS    = 24;
    localparam int FIELD_BITS  = 24;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
    localparam int MAX_TOKENS  = 3;

    localparam logic [4:0] KIND_LPAREN  = 5'd0;
    localparam logic [4:0] KIND_RPAREN  = 5'd1;
    localparam logic [4:0] KIND_LBRACE  = 5'd2;
    localparam logic [4:0] KIND_RBRACE  = 5'd3;
    localparam logic [4:0] KIND_COMMA   = 5'd4;
    localparam logic [4:0] KIND_DOT     = 5'd5;
    localparam logic [4:0] KIND_MINUS   = 5'd6;
    localparam logic [4:0] KIND_PLUS    = 5'd7;
    localparam logic [4:0] KIND_SEMI    = 5'd8;
    localparam logic [4:0] KIND_SLASH   = 5'd9;
    localparam logic [4:0] KIND_STAR    = 5'd10;
    localparam logic [4:0] KIND_BANG    = 5'd11;
    localparam logic [4:0] KIND_NE      = 5'd12;
    localparam logic [4:0] KIND_ASSIGN  = 5'd13;
    localparam logic [4:0] KIND_EQ      = 5'd14;
    localparam logic [4:0] KIND_GT      = 5'd15;
    localparam logic [4:0] KIND_GE      = 5'd16;
    localparam logic [4:0] KIND_LT      = 5'd17;
    localparam logic [4:0] KIND_LE      = 5'd18;
    localparam logic [4:0] KIND_END     = 5'd19;
    localparam logic [4:0] KIND_ERROR   = 5'd20;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NL      = 8'h0A;

    typedef enum logic [2:0] {
        PEND_NONE    = 3'd0,
        PEND_BANG    = 3'd1,
        PEND_EQUAL   = 3'd2,
        PEND_LESS    = 3'd3,
        PEND_GREATER = 3'd4,
        PEND_SLASH   = 3'd5
    } pend_t;

    typedef struct packed {
        logic [1:0]            length;
        logic [FIELD_BITS-1:0] offset;
        logic [FIELD_BITS-1:0] line;
        logic [4:0]            kind;
    } token_t;

    typedef struct packed {
        logic [1:0]                 count;
        token_t [MAX_TOKENS-1:0]    tok;
    } bundle_t;

endpackage

### src/ots_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ots_front
// Accepts source bytes, keeps scanner state and builds a token bundle for each item that yields tokens.
// ---------------------------------------------------------------------------
module ots_front import ots_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_has,
    input  logic          in_end,
    input  logic          q_full,
    output logic          q_push,
    output bundle_t       q_bundle
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    pend_t               pend_reg,   pend_next;
    logic [POS_BITS-1:0] pstart_reg, pstart_next;
    logic                cmt_reg,    cmt_next;
    logic [POS_BITS-1:0] line_reg,   line_next;
    logic [POS_BITS-1:0] pos_reg,    pos_next;
    logic                halt_reg,   halt_next;
    logic                fire;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic [FIELD_BITS-1:0] field_sat(input logic [POS_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFF_FFFF) ? {FIELD_BITS{1'b1}} : w[FIELD_BITS-1:0];
    endfunction

    function automatic logic [4:0] pend_kind(input pend_t p, input logic paired);
        logic [4:0] k;
        unique case (p)
            PEND_BANG:    k = paired ? KIND_NE : KIND_BANG;
            PEND_EQUAL:   k = paired ? KIND_EQ : KIND_ASSIGN;
            PEND_LESS:    k = paired ? KIND_LE : KIND_LT;
            PEND_GREATER: k = paired ? KIND_GE : KIND_GT;
            default:      k = KIND_SLASH;
        endcase
        return k;
    endfunction

    function automatic token_t mk_tok(input logic [4:0] kind, input logic [POS_BITS-1:0] line,
                                      input logic [POS_BITS-1:0] off, input logic [1:0] len);
        token_t t;
        t.kind   = kind;
        t.line   = field_sat(line);
        t.offset = field_sat(off);
        t.length = len;
        return t;
    endfunction

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    always_comb begin : scan
        pend_t      p;
        logic       fresh;
        logic [1:0] n;
        logic [4:0] pk;
        token_t [MAX_TOKENS-1:0] toks;

        pend_next   = pend_reg;
        pstart_next = pstart_reg;
        cmt_next    = cmt_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        halt_next   = halt_reg;
        p           = PEND_NONE;
        fresh       = 1'b0;
        n           = 2'd0;
        pk          = KIND_ERROR;
        toks        = '0;

        if (in_has) begin
            if (halt_reg) begin
                fresh = 1'b0;
            end else if (cmt_reg) begin
                if (in_byte == CH_NL) begin
                    cmt_next  = 1'b0;
                    line_next = sat_inc(line_reg);
                end
            end else if (pend_reg != PEND_NONE) begin
                p         = pend_reg;
                pend_next = PEND_NONE;
                if (p == PEND_SLASH && in_byte == CH_SLASH) begin
                    cmt_next = 1'b1;
                end else if (p != PEND_SLASH && in_byte == CH_EQUAL) begin
                    toks[n] = mk_tok(pend_kind(p, 1'b1), line_next, pstart_reg, 2'd2);
                    n = n + 2'd1;
                end else begin
                    toks[n] = mk_tok(pend_kind(p, 1'b0), line_next, pstart_reg, 2'd1);
                    n = n + 2'd1;
                    fresh = 1'b1;
                end
            end else begin
                fresh = 1'b1;
            end

            if (fresh) begin
                pk = KIND_ERROR;
                unique case (in_byte)
                    CH_LPAREN:  pk = KIND_LPAREN;
                    CH_RPAREN:  pk = KIND_RPAREN;
                    CH_LBRACE:  pk = KIND_LBRACE;
                    CH_RBRACE:  pk = KIND_RBRACE;
                    CH_COMMA:   pk = KIND_COMMA;
                    CH_DOT:     pk = KIND_DOT;
                    CH_MINUS:   pk = KIND_MINUS;
                    CH_PLUS:    pk = KIND_PLUS;
                    CH_SEMI:    pk = KIND_SEMI;
                    CH_STAR:    pk = KIND_STAR;
                    CH_BANG: begin
                        pend_next = PEND_BANG;    pstart_next = pos_reg; pk = KIND_END;
                    end
                    CH_EQUAL: begin
                        pend_next = PEND_EQUAL;   pstart_next = pos_reg; pk = KIND_END;
                    end
                    CH_LESS: begin
                        pend_next = PEND_LESS;    pstart_next = pos_reg; pk = KIND_END;
                    end
                    CH_GREATER: begin
                        pend_next = PEND_GREATER; pstart_next = pos_reg; pk = KIND_END;
                    end
                    CH_SLASH: begin
                        pend_next = PEND_SLASH;   pstart_next = pos_reg; pk = KIND_END;
                    end
                    CH_SPACE, CH_TAB, CH_CR: pk = KIND_END;
                    CH_NL: begin
                        line_next = sat_inc(line_reg); pk = KIND_END;
                    end
                    default: begin
                        pk = KIND_ERROR;
                        halt_next = 1'b1;
                    end
                endcase
                // KIND_END marks "no token" here
                if (pk != KIND_END) begin
                    toks[n] = mk_tok(pk, line_next, pos_reg, 2'd1);
                    n = n + 2'd1;
                end
            end
            pos_next = sat_inc(pos_reg);
        end

        if (in_end) begin
            if (pend_next != PEND_NONE && !halt_next) begin
                toks[n] = mk_tok(pend_kind(pend_next, 1'b0), line_next, pstart_next, 2'd1);
                n = n + 2'd1;
            end
            toks[n] = mk_tok(KIND_END, line_next, pos_next, 2'd0);
            n = n + 2'd1;
            pend_next   = PEND_NONE;
            pstart_next = '0;
            cmt_next    = 1'b0;
            line_next   = POS_BITS'(1);
            pos_next    = '0;
            halt_next   = 1'b0;
        end

        q_bundle.count = n;
        q_bundle.tok   = toks;
        q_push         = fire && (n != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= PEND_NONE;
            pstart_reg <= '0;
            cmt_reg    <= 1'b0;
            line_reg   <= POS_BITS'(1);
            pos_reg    <= '0;
            halt_reg   <= 1'b0;
        end else if (fire) begin
            pend_reg   <= pend_next;
            pstart_reg <= pstart_next;
            cmt_reg    <= cmt_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

### src/ots_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ots_queue
// Small FIFO of token bundles between the scanner front and the token sender.
// ---------------------------------------------------------------------------
module ots_queue import ots_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    output logic    head_valid,
    output bundle_t head_data,
    input  logic    pop
);

    bundle_t                mem [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   cnt_reg;
    logic                   do_pop;

    assign full       = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if ((push && !full) && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_BITS'(1);
            end else if (!(push && !full) && do_pop) begin
                cnt_reg <= cnt_reg - QCNT_BITS'(1);
            end
        end
    end

endmodule

### src/ots_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ots_back
// Walks each queued bundle and sends its tokens one per transfer through an
// output register.
// ---------------------------------------------------------------------------
module ots_back import ots_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  bundle_t head_data,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output token_t  out_tok,
    output logic    out_last
);

    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    token_t     tok_reg,   tok_next;
    logic       last_reg,  last_next;
    logic       load;
    logic       is_last;

    assign load    = !valid_reg || out_ready;
    assign is_last = (idx_reg == 2'(head_data.count - 2'd1));

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                tok_next  = head_data.tok[idx_reg];
                last_next = is_last;
                if (is_last) begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

endmodule

### src/operator_token_scanner_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// operator_token_scanner_core
// Operator and punctuator scanner over a byte stream.
//
// Input stream: one source byte per transfer on s_tdata; s_tuser says the
// byte is valid, s_tlast marks end of source after this byte (an item with
// s_tuser low and s_tlast high only ends the source).
// Output stream: one token per transfer; m_tlast marks the last token
// caused by one input transfer.
// Path: each token is registered in the bundle queue, then in the output register.
// Throughput: one input byte per clock while each byte causes at most one
// token and m_tready stays high; a byte that causes two or three tokens
// sends them one per output transfer through the single output register. A
// four-entry bundle queue between front and back absorbs such bursts.
// Reset: aresetn low clears the scanner to line 1, offset 0, no pending
// operator, and empties the queue and output register.
// Stall: with m_tready low the output holds; input is taken until the
// queue fills, then s_tready drops.
// ---------------------------------------------------------------------------
module operator_token_scanner_core import ots_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] kind, [28:5] line, [52:29] offset, [54:53] length
    output logic        m_tlast    // last_of_run
);

    logic    q_push;
    bundle_t q_bundle;
    logic    q_full;
    logic    q_valid;
    bundle_t q_head;
    logic    q_pop;
    token_t  out_tok;

    ots_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_has   (s_tuser),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_bundle)
    );

    ots_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_bundle),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop)
    );

    ots_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_tok    (out_tok),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_tok};

endmodule

### sim/operator_token_scanner_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// operator_token_scanner_core_test
// Self-checking bench for the operator token scanner.
//
// A queue of source bytes is filled up front: a short directed list of
// operator pairs, comments, errors, end-only and empty transfers, then random
// sources built mostly from legal lexemes, with stray bytes mixed in. A clocked
// driver sends them with random gaps. Each accepted transfer runs through a
// local scanner model, and its tokens are queued. A clocked monitor checks
// every output transfer against that queue. The receiver stalls at random.
// It also holds off once for a long stretch, so that the internal queue fills.
// ---------------------------------------------------------------------------
module operator_token_scanner_core_test;
    import ots_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_byte;
        logic       end_src;
    } source_item_t;

    typedef struct packed {
        logic   last;
        token_t tok;
    } scan_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    source_item_t source_items[$];
    scan_result_t expected_tokens[$];
    token_t       run_tokens[$];

    // scanner model state
    pend_t        pend_op;
    logic [23:0]  pend_start;
    logic [23:0]  line_no;
    logic [23:0]  byte_pos;
    logic         in_comment;
    logic         halted;

    int unsigned  accepted_count = 0;
    int unsigned  send_wait      = 0;
    int unsigned  recv_wait      = 0;
    int unsigned  next_gap       = 0;
    logic         receiver_hold  = 1'b0;
    int unsigned  mismatch_count = 0;
    int unsigned  tokens_checked = 0;
    int unsigned  error_tokens   = 0;
    int unsigned  bytes_scanned  = 0;
    int unsigned  sources_closed = 0;
    source_item_t next_item;
    token_t       got_tok;
    scan_result_t want;

    operator_token_scanner_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // ---------------- scanner model ----------------

    function automatic void clear_scanner();
        pend_op    = PEND_NONE;
        pend_start = '0;
        in_comment = 1'b0;
        line_no    = 24'd1;
        byte_pos   = '0;
        halted     = 1'b0;
    endfunction

    function automatic logic [23:0] bump(input logic [23:0] v);
        return (&v) ? v : v + 24'd1;
    endfunction

    // one transfer yields at most MAX_TOKENS tokens; extras are dropped
    function automatic void emit_token(input logic [4:0] kind, input logic [23:0] offset,
                                       input logic [1:0] length);
        token_t t;
        if (run_tokens.size() < MAX_TOKENS) begin
            t.kind   = kind;
            t.line   = line_no;
            t.offset = offset;
            t.length = length;
            run_tokens.insert(run_tokens.size(), t);
        end
    endfunction

    function automatic logic [4:0] pend_kind(input pend_t op, input logic paired);
        case (op)
            PEND_BANG:    return paired ? KIND_NE : KIND_BANG;
            PEND_EQUAL:   return paired ? KIND_EQ : KIND_ASSIGN;
            PEND_LESS:    return paired ? KIND_LE : KIND_LT;
            PEND_GREATER: return paired ? KIND_GE : KIND_GT;
            default:      return KIND_SLASH;
        endcase
    endfunction

    function automatic void hold_operator(input pend_t op);
        pend_op    = op;
        pend_start = byte_pos;
    endfunction

    function automatic void scan_fresh(input logic [7:0] ch);
        case (ch)
            CH_LPAREN:  emit_token(KIND_LPAREN, byte_pos, 2'd1);
            CH_RPAREN:  emit_token(KIND_RPAREN, byte_pos, 2'd1);
            CH_LBRACE:  emit_token(KIND_LBRACE, byte_pos, 2'd1);
            CH_RBRACE:  emit_token(KIND_RBRACE, byte_pos, 2'd1);
            CH_COMMA:   emit_token(KIND_COMMA, byte_pos, 2'd1);
            CH_DOT:     emit_token(KIND_DOT, byte_pos, 2'd1);
            CH_MINUS:   emit_token(KIND_MINUS, byte_pos, 2'd1);
            CH_PLUS:    emit_token(KIND_PLUS, byte_pos, 2'd1);
            CH_SEMI:    emit_token(KIND_SEMI, byte_pos, 2'd1);
            CH_STAR:    emit_token(KIND_STAR, byte_pos, 2'd1);
            CH_BANG:    hold_operator(PEND_BANG);
            CH_EQUAL:   hold_operator(PEND_EQUAL);
            CH_LESS:    hold_operator(PEND_LESS);
            CH_GREATER: hold_operator(PEND_GREATER);
            CH_SLASH:   hold_operator(PEND_SLASH);
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_NL:      line_no = bump(line_no);
            default: begin
                emit_token(KIND_ERROR, byte_pos, 2'd1);
                halted = 1'b1;
            end
        endcase
    endfunction

    function automatic void take_byte(input logic [7:0] ch);
        pend_t op;
        if (!halted) begin
            if (in_comment) begin
                if (ch == CH_NL) begin
                    in_comment = 1'b0;
                    line_no    = bump(line_no);
                end
            end else if (pend_op != PEND_NONE) begin
                op      = pend_op;
                pend_op = PEND_NONE;
                if (op == PEND_SLASH && ch == CH_SLASH) begin
                    in_comment = 1'b1;
                end else if (op != PEND_SLASH && ch == CH_EQUAL) begin
                    emit_token(pend_kind(op, 1'b1), pend_start, 2'd2);
                end else begin
                    emit_token(pend_kind(op, 1'b0), pend_start, 2'd1);
                    scan_fresh(ch);
                end
            end else begin
                scan_fresh(ch);
            end
        end
        byte_pos = bump(byte_pos);
    endfunction

    function automatic void scan_item(input logic [7:0] ch, input logic has_byte,
                                      input logic end_src);
        scan_result_t r;
        run_tokens.delete();
        if (has_byte) begin
            take_byte(ch);
            bytes_scanned++;
        end
        if (end_src) begin
            if (pend_op != PEND_NONE && !halted)
                emit_token(pend_kind(pend_op, 1'b0), pend_start, 2'd1);
            emit_token(KIND_END, byte_pos, 2'd0);
            clear_scanner();
            sources_closed++;
        end
        foreach (run_tokens[i]) begin
            r.tok  = run_tokens[i];
            r.last = (i == run_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), r);
        end
    endfunction

    // ---------------- traffic shaping ----------------

    // 0: both sides idle at random, 1: no idling, 2: sender flat out, receiver stalls
    function automatic int unsigned traffic_phase();
        return (accepted_count / 40) % 3;
    endfunction

    function automatic int unsigned sender_gap();
        if (traffic_phase() == 0)
            return $urandom_range(0, 17);
        return 0;
    endfunction

    function automatic int unsigned receiver_gap();
        if (traffic_phase() == 1)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_item(s_tdata, s_tuser, s_tlast);
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    s_tvalid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (source_items.size() != 0) begin
                    next_item  = source_items.pop_front();
                    s_tdata   <= next_item.ch;
                    s_tuser   <= next_item.has_byte;
                    s_tlast   <= next_item.end_src;
                    s_tvalid  <= 1'b1;
                    send_wait <= sender_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (receiver_hold) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            next_gap   = receiver_gap();
            recv_wait <= next_gap;
            m_tready  <= (next_gap == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= (recv_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long hold-off while the sender keeps going
    initial begin
        while (accepted_count < 60)
            @(posedge aclk);
        receiver_hold <= 1'b1;
        repeat (150) @(posedge aclk);
        receiver_hold <= 1'b0;
    end

    // ---------------- monitor ----------------

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %0t: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_tok = token_t'(m_tdata[54:0]);
            tokens_checked++;
            if (got_tok.kind == KIND_ERROR)
                error_tokens++;
            if (expected_tokens.size() == 0) begin
                note_failure($sformatf("unexpected token kind %0d line %0d offset %0d len %0d",
                                       got_tok.kind, got_tok.line, got_tok.offset,
                                       got_tok.length));
            end else begin
                want = expected_tokens.pop_front();
                if (got_tok.kind !== want.tok.kind || got_tok.line !== want.tok.line ||
                    got_tok.offset !== want.tok.offset ||
                    got_tok.length !== want.tok.length ||
                    m_tlast !== want.last || m_tdata[55] !== 1'b0)
                    note_failure($sformatf({"expected kind %0d line %0d offset %0d len %0d ",
                                            "last %0b, got kind %0d line %0d offset %0d ",
                                            "len %0d last %0b pad %0b"},
                                           want.tok.kind, want.tok.line, want.tok.offset,
                                           want.tok.length, want.last, got_tok.kind,
                                           got_tok.line, got_tok.offset, got_tok.length,
                                           m_tlast, m_tdata[55]));
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void add_byte(input logic [7:0] ch, input logic end_src);
        source_item_t it;
        it.ch       = ch;
        it.has_byte = 1'b1;
        it.end_src  = end_src;
        source_items.insert(source_items.size(), it);
    endfunction

    function automatic void add_bare(input logic end_src);
        source_item_t it;
        it.ch       = 8'($urandom_range(0, 255));
        it.has_byte = 1'b0;
        it.end_src  = end_src;
        source_items.insert(source_items.size(), it);
    endfunction

    function automatic void add_text(input string s, input logic close_src);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], close_src && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] pick_lexeme_char();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            case ($urandom_range(0, 9))
                0: return CH_LPAREN;
                1: return CH_RPAREN;
                2: return CH_LBRACE;
                3: return CH_RBRACE;
                4: return CH_COMMA;
                5: return CH_DOT;
                6: return CH_MINUS;
                7: return CH_PLUS;
                8: return CH_SEMI;
                default: return CH_STAR;
            endcase
        end else if (roll < 70) begin
            case ($urandom_range(0, 4))
                0: return CH_BANG;
                1: return CH_EQUAL;
                2: return CH_LESS;
                3: return CH_GREATER;
                default: return CH_SLASH;
            endcase
        end else if (roll < 80) begin
            return CH_EQUAL;
        end else if (roll < 92) begin
            case ($urandom_range(0, 2))
                0: return CH_SPACE;
                1: return CH_TAB;
                default: return CH_CR;
            endcase
        end
        return CH_NL;
    endfunction

    initial begin
        int unsigned directed_count;
        int unsigned src_len;
        int unsigned roll;
        logic [7:0]  junk;

        clear_scanner();

        // operator pairs and singles; slash flushed by an end-only transfer
        add_text("!==<=>\t/", 1'b0);
        add_bare(1'b1);
        // three tokens from one transfer
        add_text("==>=!(", 1'b1);
        // comment up to newline, error on the next line, bytes ignored after it
        add_text("//c\n", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CH_BANG, 1'b1);
        // pending op, then another op closing the source: both flushed, then END
        add_text("!<", 1'b1);
        // empty transfer, then a comment that runs into end of source
        add_bare(1'b0);
        add_text("//", 1'b1);
        directed_count = source_items.size();

        while (source_items.size() - directed_count < 250) begin
            src_len = $urandom_range(1, 24);
            for (int n = 0; n < src_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end else if (roll < 5) begin
                    add_bare(1'b0);
                end else if (roll < 10) begin
                    add_text("//", 1'b0);
                    repeat ($urandom_range(0, 4)) begin
                        junk = 8'($urandom_range(0, 255));
                        add_byte((junk == CH_NL) ? CH_SPACE : junk, 1'b0);
                    end
                    if ($urandom_range(0, 3) != 0)
                        add_byte(CH_NL, 1'b0);
                end else begin
                    add_byte(pick_lexeme_char(), 1'b0);
                end
            end
            if ($urandom_range(0, 1) == 0)
                add_bare(1'b1);
            else
                source_items[source_items.size() - 1].end_src = 1'b1;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (source_items.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (expected_tokens.size() != 0)
            note_failure($sformatf("%0d tokens never arrived", expected_tokens.size()));

        $display("Scanned %0d bytes over %0d sources in %0d transfers.",
                 bytes_scanned, sources_closed, accepted_count);
        $display("Checked %0d tokens (%0d error tokens), %0d mismatches.",
                 tokens_checked, error_tokens, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d transfers accepted, %0d tokens outstanding.",
                 accepted_count, expected_tokens.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
